### rtl/sactr_pkg.sv
// shared types and constants of the set-associative cache tag and replacement block
// no dependencies

package sactr_pkg;

    localparam int ADDR_W  = 64;
    localparam int WAY_W   = 2;
    localparam int TOTAL_W = 32;
    localparam int POL_W   = 2;

    localparam logic [POL_W-1:0] POL_LRU  = 2'd0;
    localparam logic [POL_W-1:0] POL_LFU  = 2'd1;
    localparam logic [POL_W-1:0] POL_FIFO = 2'd2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic hit;
        logic evicted;
    } t_look_stat;

endpackage

### rtl/sactr_if.sv
// valid/ready channel interfaces for address words and result words
// depends on sactr_pkg

interface sactr_in_if;
    logic                       valid;
    logic                       ready;
    logic [sactr_pkg::ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface sactr_out_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [sactr_pkg::WAY_W-1:0]   way_used;
    logic                          replaced_valid;
    logic [sactr_pkg::TOTAL_W-1:0] hit_total;
    logic [sactr_pkg::TOTAL_W-1:0] miss_total;

    modport source (output valid, output hit, output way_used, output replaced_valid,
                    output hit_total, output miss_total, input ready);
    modport sink   (input valid, input hit, input way_used, input replaced_valid,
                    input hit_total, input miss_total, output ready);
endinterface

### rtl/sactr_policy.sv
// tag compare, victim choice and policy row update for one set
// depends on sactr_pkg

module sactr_policy #(
    parameter int WAYS       = 4,
    parameter int COUNT_BITS = 16,
    parameter int TAG_BITS   = 52,
    parameter int WB         = 2
) (
    input  logic [sactr_pkg::POL_W-1:0]       i_policy,
    input  logic [TAG_BITS-1:0]               i_tag,
    input  logic [WAYS-1:0][TAG_BITS-1:0]     i_tags,
    input  logic [WAYS-1:0]                   i_valid,
    input  logic [WAYS-1:0][WB-1:0]           i_order,
    input  logic [WAYS-1:0][COUNT_BITS-1:0]   i_cnt,
    input  logic [WB-1:0]                     i_fifo,
    output logic [WB-1:0]                     o_way,
    output sactr_pkg::t_look_stat             o_stat,
    output logic [WAYS-1:0]                   o_valid,
    output logic [WAYS-1:0][WB-1:0]           o_order,
    output logic [WAYS-1:0][COUNT_BITS-1:0]   o_cnt,
    output logic [WB-1:0]                     o_fifo
);
    import sactr_pkg::*;

    logic                  hit;
    logic [WB-1:0]         hit_way;
    logic                  free;
    logic [WB-1:0]         free_way;
    logic [WB-1:0]         lfu_way;
    logic [COUNT_BITS-1:0] lfu_cnt;
    logic [WB-1:0]         fifo_inc;
    logic [WB-1:0]         victim;
    logic [WB-1:0]         way;
    logic [WB-1:0]         pos;
    logic                  pos_found;

    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        lfu_way  = '0;
        lfu_cnt  = i_cnt[0];
        for (int i = 0; i < WAYS; i++) begin
            if (!hit && i_valid[i] && i_tags[i] == i_tag) begin
                hit     = 1'b1;
                hit_way = WB'(i);
            end
            if (!free && !i_valid[i]) begin
                free     = 1'b1;
                free_way = WB'(i);
            end
        end
        for (int i = 1; i < WAYS; i++) begin
            if (i_cnt[i] < lfu_cnt) begin
                lfu_cnt = i_cnt[i];
                lfu_way = WB'(i);
            end
        end
    end

    assign fifo_inc = (i_fifo == WB'(WAYS - 1)) ? '0 : i_fifo + WB'(1);

    always_comb begin
        case (i_policy)
            POL_LFU:  victim = lfu_way;
            POL_FIFO: victim = i_fifo;
            default:  victim = i_order[0];
        endcase
    end

    assign way = hit ? hit_way : (free ? free_way : victim);

    always_comb begin
        pos       = WB'(WAYS - 1);
        pos_found = 1'b0;
        for (int i = 0; i < WAYS; i++) begin
            if (!pos_found && i_order[i] == way) begin
                pos       = WB'(i);
                pos_found = 1'b1;
            end
        end
        o_order = i_order;
        for (int i = 0; i < WAYS - 1; i++) begin
            if (WB'(i) >= pos) begin
                o_order[i] = i_order[i + 1];
            end
        end
        o_order[WAYS-1] = way;
    end

    always_comb begin
        o_valid = i_valid;
        o_cnt   = i_cnt;
        o_fifo  = i_fifo;
        if (hit) begin
            if (i_cnt[way] != '1) begin
                o_cnt[way] = i_cnt[way] + COUNT_BITS'(1);
            end
        end else begin
            o_valid[way] = 1'b1;
            o_cnt[way]   = '0;
            if (!free && i_policy == POL_FIFO) begin
                o_fifo = fifo_inc;
            end
        end
    end

    assign o_way          = way;
    assign o_stat.hit     = hit;
    assign o_stat.evicted = !hit && !free;

endmodule

### rtl/set_assoc_cache_tag_replacement.sv
// top level of the set-associative cache tag and replacement block
// depends on sactr_pkg, sactr_if (sactr_in_if, sactr_out_if) and sactr_policy
//
// usage: one address word per access on i_in; one result word per access on o_out
// (hit, way used, eviction flag and saturating hit and miss totals).
// i_cfg_wr_en/i_cfg_wr_data write the replacement policy (0 lru, 1 lfu, 2 fifo,
// 3 acts as lru); write it only while no access is in flight.
// SET_COUNT and BLOCK_BYTES are powers of two.
// each access: the accept edge reads the set's tag row and policy row from two
// synchronous memories; in ST_LOOK, once the result register is free or being
// read, the block compares, picks the way, writes the policy row back (the tag
// row only on a miss) and loads the result register that drives o_out. no new
// address is taken before write-back, bound by the read-modify-write of set rows.
// the output register lets a new address be taken while a result waits; a
// second access holds before write-back until the waiting result is taken.
// after reset a clearing pass writes the policy memory, one set per cycle, for
// every set; i_in.ready stays low until it ends. tags are not cleared.

module set_assoc_cache_tag_replacement #(
    parameter int SET_COUNT   = 64,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 64,
    parameter int COUNT_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [sactr_pkg::POL_W-1:0] i_cfg_wr_data,
    sactr_in_if.sink                    i_in,
    sactr_out_if.source                 o_out
);
    import sactr_pkg::*;

    localparam int OFF_BITS = $clog2(BLOCK_BYTES);
    localparam int SET_BITS = $clog2(SET_COUNT);
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_BITS = ADDR_W - OFF_BITS - SET_BITS;
    localparam int WB       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ORD_LO   = WAYS;
    localparam int CNT_LO   = ORD_LO + WAYS * WB;
    localparam int FIFO_LO  = CNT_LO + WAYS * COUNT_BITS;
    localparam int ROW_W    = FIFO_LO + WB;

    t_state r_state;
    t_state n_state;

    logic [POL_W-1:0] r_policy;

    logic [WAYS-1:0][TAG_BITS-1:0] tag_mem [SET_COUNT];
    logic [ROW_W-1:0]              pol_mem [SET_COUNT];

    logic [WAYS-1:0][TAG_BITS-1:0] r_tag_rd;
    logic [ROW_W-1:0]              r_pol_rd;
    logic [SET_W-1:0]              r_set;
    logic [TAG_BITS-1:0]           r_tag;
    logic [SET_W-1:0]              r_clr_idx;

    logic [ADDR_W-1:0]   in_block;
    logic [SET_W-1:0]    in_set;
    logic [TAG_BITS-1:0] in_tag;

    logic                 accept;
    logic                 finish;
    logic                 clr_last;
    logic                 pol_we;
    logic [SET_W-1:0]     pol_waddr;
    logic [ROW_W-1:0]     pol_wdata;
    logic [ROW_W-1:0]     new_row;
    logic [WAYS-1:0][WB-1:0] rst_order;

    logic [WAYS-1:0]                 rd_valid;
    logic [WAYS-1:0][WB-1:0]         rd_order;
    logic [WAYS-1:0][COUNT_BITS-1:0] rd_cnt;
    logic [WB-1:0]                   rd_fifo;

    logic [WB-1:0]                   way;
    t_look_stat                      stat;
    logic [WAYS-1:0]                 nw_valid;
    logic [WAYS-1:0][WB-1:0]         nw_order;
    logic [WAYS-1:0][COUNT_BITS-1:0] nw_cnt;
    logic [WB-1:0]                   nw_fifo;
    logic [WB+1:0]                   way_ext;
    logic [WAYS-1:0][TAG_BITS-1:0]   nw_tags;

    logic [TOTAL_W-1:0] r_hit_cnt;
    logic [TOTAL_W-1:0] r_miss_cnt;
    logic [TOTAL_W-1:0] n_hit_cnt;
    logic [TOTAL_W-1:0] n_miss_cnt;

    logic               r_out_valid;
    logic               r_out_hit;
    logic [WAY_W-1:0]   r_out_way;
    logic               r_out_repl;
    logic [TOTAL_W-1:0] r_out_hit_total;
    logic [TOTAL_W-1:0] r_out_miss_total;

    // address split
    assign in_block = i_in.address >> OFF_BITS;
    assign in_set   = SET_W'(in_block & ADDR_W'(SET_COUNT - 1));
    assign in_tag   = TAG_BITS'(in_block >> SET_BITS);

    assign rd_valid = r_pol_rd[WAYS-1:0];
    assign rd_order = r_pol_rd[CNT_LO-1:ORD_LO];
    assign rd_cnt   = r_pol_rd[FIFO_LO-1:CNT_LO];
    assign rd_fifo  = r_pol_rd[ROW_W-1:FIFO_LO];

    sactr_policy #(
        .WAYS       (WAYS),
        .COUNT_BITS (COUNT_BITS),
        .TAG_BITS   (TAG_BITS),
        .WB         (WB)
    ) u_policy (
        .i_policy (r_policy),
        .i_tag    (r_tag),
        .i_tags   (r_tag_rd),
        .i_valid  (rd_valid),
        .i_order  (rd_order),
        .i_cnt    (rd_cnt),
        .i_fifo   (rd_fifo),
        .o_way    (way),
        .o_stat   (stat),
        .o_valid  (nw_valid),
        .o_order  (nw_order),
        .o_cnt    (nw_cnt),
        .o_fifo   (nw_fifo)
    );

    assign new_row = {nw_fifo, nw_cnt, nw_order, nw_valid};
    assign way_ext = {2'b00, way};

    always_comb begin
        nw_tags      = r_tag_rd;
        nw_tags[way] = r_tag;
    end

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            rst_order[i] = WB'(i);
        end
    end

    assign clr_last = (r_clr_idx == SET_W'(SET_COUNT - 1));

    always_comb begin
        n_state   = r_state;
        accept    = 1'b0;
        finish    = 1'b0;
        pol_we    = 1'b0;
        pol_waddr = r_set;
        pol_wdata = new_row;
        case (r_state)
            ST_CLEAR: begin
                pol_we    = 1'b1;
                pol_waddr = r_clr_idx;
                pol_wdata = {WB'(0), {(WAYS * COUNT_BITS){1'b0}}, rst_order, {WAYS{1'b0}}};
                if (clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                accept = i_in.valid;
                if (i_in.valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!r_out_valid || o_out.ready) begin
                    finish  = 1'b1;
                    pol_we  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign i_in.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_LRU;
        end else if (i_cfg_wr_en) begin
            r_policy <= i_cfg_wr_data;
        end
    end

    // set rows
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag_rd <= tag_mem[in_set];
            r_pol_rd <= pol_mem[in_set];
            r_set    <= in_set;
            r_tag    <= in_tag;
        end
        if (finish && !stat.hit) begin
            tag_mem[r_set] <= nw_tags;
        end
        if (pol_we) begin
            pol_mem[pol_waddr] <= pol_wdata;
        end
    end

    assign n_hit_cnt  = (stat.hit && r_hit_cnt != TOTAL_MAX) ?
                        r_hit_cnt + TOTAL_W'(1) : r_hit_cnt;
    assign n_miss_cnt = (!stat.hit && r_miss_cnt != TOTAL_MAX) ?
                        r_miss_cnt + TOTAL_W'(1) : r_miss_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (finish) begin
                r_hit_cnt   <= n_hit_cnt;
                r_miss_cnt  <= n_miss_cnt;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_hit        <= stat.hit;
            r_out_way        <= way_ext[WAY_W-1:0];
            r_out_repl       <= stat.evicted;
            r_out_hit_total  <= n_hit_cnt;
            r_out_miss_total <= n_miss_cnt;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.hit            = r_out_hit;
    assign o_out.way_used       = r_out_way;
    assign o_out.replaced_valid = r_out_repl;
    assign o_out.hit_total      = r_out_hit_total;
    assign o_out.miss_total     = r_out_miss_total;

endmodule

### rtl/sactr_checker.sv
// port-level checks of the cache tag and replacement block, bound to its top level
// depends on sactr_pkg and set_assoc_cache_tag_replacement

module sactr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_hit,
    input logic                          i_out_repl,
    input logic [sactr_pkg::TOTAL_W-1:0] i_out_hit_total
);
    import sactr_pkg::*;

    // stalled word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hit_total))
        else $error("stalled result word changed");

    // a hit never reports an eviction
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_hit |-> !i_out_repl)
        else $error("hit with eviction flag");

    // one access at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("address taken during an access");

    // a result word is shown after each accepted address
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> ##1 i_out_valid)
        else $error("result word missing after access");

    // reset empties the block
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("block busy after reset");

endmodule

bind set_assoc_cache_tag_replacement sactr_checker u_sactr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_hit       (o_out.hit),
    .i_out_repl      (o_out.replaced_valid),
    .i_out_hit_total (o_out.hit_total)
);
